// File: hdl/assert_macros.svh
// Assertion macros used by the top RTL file of the homography point mapper.
// Each macro expands to one labeled concurrent assertion on clk; ASSERT_CLK is gated by rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/hpmd_pkg.sv
// Package for the homography point mapper: widths, register codes, payload types.
// No dependencies; the other .sv files import it.
`default_nettype none

package hpmd_pkg;

    localparam int COORD_W    = 16;
    localparam int COEF_W     = 32;
    localparam int NUM_REGS   = 8;
    localparam int IDX_W      = $clog2(NUM_REGS);
    localparam int PROD_W     = COEF_W + COORD_W + 1;
    localparam int SUM_W      = PROD_W + 3;
    localparam int FRAC_SH    = 20;
    localparam int DIV_STEPS  = 20;
    localparam int NUM_W      = SUM_W + FRAC_SH + 2;
    localparam int MAP_W      = 20;
    localparam int DIST_W     = 20;
    localparam int DIFF_W     = ((COORD_W + 1 > MAP_W) ? COORD_W + 1 : MAP_W) + 1;
    localparam int SQ_W       = 2 * MAP_W + 2;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int W_ONE_SH   = 36;

    localparam logic signed [MAP_W-1:0] MAP_MAX  = {1'b0, {(MAP_W-1){1'b1}}};
    localparam logic signed [MAP_W-1:0] MAP_MIN  = {1'b1, {(MAP_W-1){1'b0}}};
    localparam logic [DIST_W-1:0]       DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [IDX_W-1:0] {
        REG_COEF_XX = 3'd0,
        REG_COEF_XY = 3'd1,
        REG_COEF_XT = 3'd2,
        REG_COEF_YX = 3'd3,
        REG_COEF_YY = 3'd4,
        REG_COEF_YT = 3'd5,
        REG_PERSP_X = 3'd6,
        REG_PERSP_Y = 3'd7
    } cfg_reg_t;

    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(65536);

    typedef struct packed {
        logic [MAP_W-1:0]  mapped_x;
        logic [MAP_W-1:0]  mapped_y;
        logic [DIST_W-1:0] distance;
        logic              zero_scale;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/hpmd_channels.sv
// Valid/ready channel interfaces for the point input and the result output.
// Depends on hpmd_pkg for field widths.
`default_nettype none

interface hpmd_point_if import hpmd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [COORD_W-1:0] target_x;
    logic [COORD_W-1:0] target_y;

    modport source (output valid, src_x, src_y, target_x, target_y, input ready);
    modport sink   (input valid, src_x, src_y, target_x, target_y, output ready);
endinterface

interface hpmd_result_if import hpmd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MAP_W-1:0]  mapped_x;
    logic [MAP_W-1:0]  mapped_y;
    logic [DIST_W-1:0] distance;
    logic              zero_scale;

    modport source (output valid, mapped_x, mapped_y, distance, zero_scale, input ready);
    modport sink   (input valid, mapped_x, mapped_y, distance, zero_scale, output ready);
endinterface

`default_nettype wire

// File: hdl/homography_point_map_distance.sv
// Homography point mapper with distance to a target point.
// Point channel in, result channel out, plain register write port.
// Each transfer on point carries a source and a target point (unsigned Q12.4).
// The source is mapped through the 3x3 homography held in eight 32-bit registers
// (write cfg_we/cfg_index/cfg_data while idle; h22 is fixed at 1.0) and divided
// by w. The result carries the mapped point (signed Q16.4, saturated), its
// rounded Euclidean distance to the target (unsigned Q16.4, saturated) and
// zero_scale, set when w is zero.
// Throughput: one item per cycle while the skid register is empty. Depth: 49
// register stages, made up of the 20-stage divider and the 21-stage square root
// plus multiply, sum and fixup stages and the output register.
// Reset loads the identity matrix and empties the pipeline; no clearing pass.
// When the receiver stalls, one result parks in a skid register and the whole
// pipeline holds; point.ready is a register and drops while the skid is full.
// No item is lost or repeated across stalls.
`default_nettype none

module homography_point_map_distance import hpmd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [COEF_W-1:0] cfg_data,
    hpmd_point_if.sink             point,
    hpmd_result_if.source          result
);

`include "assert_macros.svh"

    typedef struct packed {
        logic [COORD_W-1:0]      tx;
        logic [COORD_W-1:0]      ty;
        logic                    zero;
        logic                    negx;
        logic                    negy;
        logic [MAP_W-1:0]        zmx;
        logic [MAP_W-1:0]        zmy;
    } div_side_t;

    typedef struct packed {
        logic [MAP_W-1:0] mx;
        logic [MAP_W-1:0] my;
        logic             zero;
        logic             big;
    } sq_side_t;

    localparam logic signed [SUM_W-1:0] W_ONE = SUM_W'(1) << W_ONE_SH;

    // configuration
    logic [COEF_W-1:0] coef_reg [NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
            coef_reg[REG_COEF_XX] <= COEF_ONE;
            coef_reg[REG_COEF_YY] <= COEF_ONE;
        end
        else if (cfg_we)
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // global advance: hold everything while the skid register is full
    logic en;
    logic skid_v_reg;
    assign en = !skid_v_reg;
    assign point.ready = en;

    logic in_xfer;
    assign in_xfer = point.valid && en;

    // stage 1: products
    logic signed [PROD_W-1:0] pxx_reg, pxy_reg, pyx_reg, pyy_reg, ppx_reg, ppy_reg;
    logic signed [COEF_W+3:0] xt16_reg, yt16_reg;
    logic [COORD_W-1:0]       tx1_reg, ty1_reg;
    logic                     v1_reg;
    logic signed [COORD_W:0]  sx_s, sy_s;

    assign sx_s = $signed({1'b0, point.src_x});
    assign sy_s = $signed({1'b0, point.src_y});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxx_reg  <= $signed(coef_reg[REG_COEF_XX]) * sx_s;
            pxy_reg  <= $signed(coef_reg[REG_COEF_XY]) * sy_s;
            pyx_reg  <= $signed(coef_reg[REG_COEF_YX]) * sx_s;
            pyy_reg  <= $signed(coef_reg[REG_COEF_YY]) * sy_s;
            ppx_reg  <= $signed(coef_reg[REG_PERSP_X]) * sx_s;
            ppy_reg  <= $signed(coef_reg[REG_PERSP_Y]) * sy_s;
            xt16_reg <= $signed({coef_reg[REG_COEF_XT], 4'b0000});
            yt16_reg <= $signed({coef_reg[REG_COEF_YT], 4'b0000});
            tx1_reg  <= point.target_x;
            ty1_reg  <= point.target_y;
        end
    end

    // stage 2: homogeneous sums
    logic signed [SUM_W-1:0] x2_reg, y2_reg, w2_reg;
    logic [COORD_W-1:0]      tx2_reg, ty2_reg;
    logic                    v2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg  <= SUM_W'(pxx_reg) + SUM_W'(pxy_reg) + SUM_W'(xt16_reg);
            y2_reg  <= SUM_W'(pyx_reg) + SUM_W'(pyy_reg) + SUM_W'(yt16_reg);
            w2_reg  <= SUM_W'(ppx_reg) + SUM_W'(ppy_reg) + W_ONE;
            tx2_reg <= tx1_reg;
            ty2_reg <= ty1_reg;
        end
    end

    // stage 3: divider operands
    logic [SUM_W-1:0] absx, absy, absw;
    logic [NUM_W-1:0] numx_next, numy_next, den_next;
    div_side_t        side3_next;

    assign absx = x2_reg[SUM_W-1] ? SUM_W'(-x2_reg) : SUM_W'(x2_reg);
    assign absy = y2_reg[SUM_W-1] ? SUM_W'(-y2_reg) : SUM_W'(y2_reg);
    assign absw = w2_reg[SUM_W-1] ? SUM_W'(-w2_reg) : SUM_W'(w2_reg);
    assign numx_next = (NUM_W'(absx) << (FRAC_SH + 1)) + NUM_W'(absw);
    assign numy_next = (NUM_W'(absy) << (FRAC_SH + 1)) + NUM_W'(absw);
    assign den_next  = NUM_W'(absw) << 1;

    always_comb
    begin
        side3_next.tx   = tx2_reg;
        side3_next.ty   = ty2_reg;
        side3_next.zero = (w2_reg == '0);
        side3_next.negx = x2_reg[SUM_W-1] ^ w2_reg[SUM_W-1];
        side3_next.negy = y2_reg[SUM_W-1] ^ w2_reg[SUM_W-1];
        side3_next.zmx  = (x2_reg == '0) ? '0 : (x2_reg[SUM_W-1] ? MAP_MIN : MAP_MAX);
        side3_next.zmy  = (y2_reg == '0) ? '0 : (y2_reg[SUM_W-1] ? MAP_MIN : MAP_MAX);
    end

    logic [NUM_W-1:0] numx_reg, numy_reg, den_reg;
    logic             satx_reg, saty_reg;
    div_side_t        side3_reg;
    logic             v3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numx_reg  <= numx_next;
            numy_reg  <= numy_next;
            den_reg   <= den_next;
            satx_reg  <= (numx_next >= (den_next << DIV_STEPS));
            saty_reg  <= (numy_next >= (den_next << DIV_STEPS));
            side3_reg <= side3_next;
        end
    end

    // dividers
    logic [DIV_STEPS:0] qx, qy;

    hpmd_div_pipe u_div_x
    (
        .clk  (clk),
        .en   (en),
        .num  (numx_reg),
        .den  (den_reg),
        .sat  (satx_reg),
        .quot (qx)
    );

    hpmd_div_pipe u_div_y
    (
        .clk  (clk),
        .en   (en),
        .num  (numy_reg),
        .den  (den_reg),
        .sat  (saty_reg),
        .quot (qy)
    );

    div_side_t            dside_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] dv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dside_reg[0] <= side3_reg;
            for (int i = 1; i < DIV_STEPS; i++)
            begin
                dside_reg[i] <= dside_reg[i-1];
            end
        end
    end

    // stage 4: sign, saturation, differences to target
    div_side_t          ds;
    logic [MAP_W-1:0]   mx_next, my_next;
    logic [DIV_STEPS:0] qx_neg, qy_neg;
    logic [DIFF_W-1:0]  dx, dy, adx, ady;

    assign ds     = dside_reg[DIV_STEPS-1];
    assign qx_neg = ~qx + 1'b1;
    assign qy_neg = ~qy + 1'b1;

    always_comb
    begin
        if (ds.zero)
        begin
            mx_next = ds.zmx;
            my_next = ds.zmy;
        end
        else
        begin
            if (ds.negx)
            begin
                mx_next = (qx > (DIV_STEPS+1)'(1 << (MAP_W - 1))) ? MAP_MIN : qx_neg[MAP_W-1:0];
            end
            else
            begin
                mx_next = (qx > (DIV_STEPS+1)'(MAP_MAX)) ? MAP_MAX : qx[MAP_W-1:0];
            end
            if (ds.negy)
            begin
                my_next = (qy > (DIV_STEPS+1)'(1 << (MAP_W - 1))) ? MAP_MIN : qy_neg[MAP_W-1:0];
            end
            else
            begin
                my_next = (qy > (DIV_STEPS+1)'(MAP_MAX)) ? MAP_MAX : qy[MAP_W-1:0];
            end
        end
    end

    assign dx  = {{(DIFF_W-MAP_W){mx_next[MAP_W-1]}}, mx_next} - {{(DIFF_W-COORD_W){1'b0}}, ds.tx};
    assign dy  = {{(DIFF_W-MAP_W){my_next[MAP_W-1]}}, my_next} - {{(DIFF_W-COORD_W){1'b0}}, ds.ty};
    assign adx = dx[DIFF_W-1] ? (~dx + 1'b1) : dx;
    assign ady = dy[DIFF_W-1] ? (~dy + 1'b1) : dy;

    logic [MAP_W-1:0] adx4_reg, ady4_reg;
    sq_side_t         side4_reg;
    logic             v4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adx4_reg       <= adx[MAP_W-1:0];
            ady4_reg       <= ady[MAP_W-1:0];
            side4_reg.mx   <= mx_next;
            side4_reg.my   <= my_next;
            side4_reg.zero <= ds.zero;
            side4_reg.big  <= (adx[DIFF_W-1:MAP_W] != '0) || (ady[DIFF_W-1:MAP_W] != '0);
        end
    end

    // stage 5: squares; stage 6: sum
    logic [2*MAP_W-1:0] sqx5_reg, sqy5_reg;
    sq_side_t           side5_reg;
    logic               v5_reg;
    logic [SQ_W-1:0]    sum6_reg;
    sq_side_t           side6_reg;
    logic               v6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx5_reg  <= adx4_reg * adx4_reg;
            sqy5_reg  <= ady4_reg * ady4_reg;
            side5_reg <= side4_reg;
            sum6_reg  <= SQ_W'(sqx5_reg) + SQ_W'(sqy5_reg);
            side6_reg <= side5_reg;
        end
    end

    // square root
    logic [SQ_W-1:0] root, rem;

    hpmd_sqrt_pipe u_sqrt
    (
        .clk      (clk),
        .en       (en),
        .radicand (sum6_reg),
        .root     (root),
        .rem      (rem)
    );

    sq_side_t              sside_reg [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] sv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sside_reg[0] <= side6_reg;
            for (int i = 1; i < SQRT_STEPS; i++)
            begin
                sside_reg[i] <= sside_reg[i-1];
            end
        end
    end

    // stage 7: round to nearest, saturate
    sq_side_t        ss;
    logic [SQ_W-1:0] rounded;
    result_t         res7_next;

    assign ss      = sside_reg[SQRT_STEPS-1];
    assign rounded = (rem > root) ? (root + 1'b1) : root;

    always_comb
    begin
        res7_next.mapped_x   = ss.mx;
        res7_next.mapped_y   = ss.my;
        res7_next.zero_scale = ss.zero;
        if (ss.zero || ss.big || (rounded > SQ_W'(DIST_MAX)))
        begin
            res7_next.distance = DIST_MAX;
        end
        else
        begin
            res7_next.distance = rounded[DIST_W-1:0];
        end
    end

    result_t res7_reg;
    logic    v7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res7_reg <= res7_next;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            dv_reg <= '0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            sv_reg <= '0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_xfer;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            dv_reg <= {dv_reg[DIV_STEPS-2:0], v3_reg};
            v4_reg <= dv_reg[DIV_STEPS-1];
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            sv_reg <= {sv_reg[SQRT_STEPS-2:0], v6_reg};
            v7_reg <= sv_reg[SQRT_STEPS-1];
        end
    end

    // output register and skid
    result_t out_reg, skid_reg;
    logic    out_v_reg;
    logic    out_free;
    logic    arrive;

    assign out_free = !out_v_reg || result.ready;
    assign arrive   = en && v7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_v_reg  <= skid_v_reg || arrive;
                skid_v_reg <= 1'b0;
            end
            else if (arrive)
            begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_v_reg ? skid_reg : res7_reg;
        end
        else if (arrive)
        begin
            skid_reg <= res7_reg;
        end
    end

    assign result.valid      = out_v_reg;
    assign result.mapped_x   = out_reg.mapped_x;
    assign result.mapped_y   = out_reg.mapped_y;
    assign result.distance   = out_reg.distance;
    assign result.zero_scale = out_reg.zero_scale;

    `ASSERT_ALWAYS(a_skid_needs_out, skid_v_reg |-> out_v_reg, "skid full with output empty")
    `ASSERT_CLK(a_skid_on_stall, $rose(skid_v_reg) |-> $past(out_v_reg && !result.ready), "skid filled without a stalled output")
    `ASSERT_CLK(a_zero_dist, (out_v_reg && out_reg.zero_scale) |-> (out_reg.distance == DIST_MAX), "zero w without saturated distance")

endmodule

`default_nettype wire

// File: hdl/hpmd_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, DIV_STEPS stages.
// Depends on hpmd_pkg for widths.
`default_nettype none

module hpmd_div_pipe import hpmd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [NUM_W-1:0] den,
    input  wire logic             sat,
    output logic [DIV_STEPS:0]    quot
);

    logic [NUM_W-1:0]     n_reg   [DIV_STEPS];
    logic [NUM_W-1:0]     d_reg   [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_reg   [DIV_STEPS];
    logic                 sat_reg [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_stage
            localparam int BIT = DIV_STEPS - 1 - k;
            logic [NUM_W-1:0]     n_in;
            logic [NUM_W-1:0]     d_in;
            logic [NUM_W-1:0]     trial;
            logic [DIV_STEPS-1:0] q_in;
            logic                 s_in;
            logic                 ge;

            if (k == 0)
            begin : g_first
                assign n_in = num;
                assign d_in = den;
                assign q_in = '0;
                assign s_in = sat;
            end
            else
            begin : g_rest
                assign n_in = n_reg[k-1];
                assign d_in = d_reg[k-1];
                assign q_in = q_reg[k-1];
                assign s_in = sat_reg[k-1];
            end

            assign trial = d_in << BIT;
            assign ge    = (n_in >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[k]   <= ge ? (n_in - trial) : n_in;
                    d_reg[k]   <= d_in;
                    q_reg[k]   <= q_in | (DIV_STEPS'(ge) << BIT);
                    sat_reg[k] <= s_in;
                end
            end
        end
    endgenerate

    assign quot = sat_reg[DIV_STEPS-1] ? {1'b1, {DIV_STEPS{1'b0}}}
                                       : {1'b0, q_reg[DIV_STEPS-1]};

endmodule

`default_nettype wire

// File: hdl/hpmd_sqrt_pipe.sv
// Pipelined integer square root: one root bit per stage, SQRT_STEPS stages.
// Depends on hpmd_pkg for widths; leaves the remainder for rounding.
`default_nettype none

module hpmd_sqrt_pipe import hpmd_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [SQ_W-1:0] radicand,
    output logic [SQ_W-1:0]      root,
    output logic [SQ_W-1:0]      rem
);

    logic [SQ_W-1:0] x_reg [SQRT_STEPS];
    logic [SQ_W-1:0] r_reg [SQRT_STEPS];

    genvar k;
    generate
        for (k = 0; k < SQRT_STEPS; k++)
        begin : g_stage
            localparam int SH = SQ_W - 2 - 2 * k;
            logic [SQ_W-1:0] x_in;
            logic [SQ_W-1:0] r_in;
            logic [SQ_W-1:0] trial;
            logic [SQ_W-1:0] bit_val;
            logic            ge;

            if (k == 0)
            begin : g_first
                assign x_in = radicand;
                assign r_in = '0;
            end
            else
            begin : g_rest
                assign x_in = x_reg[k-1];
                assign r_in = r_reg[k-1];
            end

            assign bit_val = SQ_W'(1) << SH;
            assign trial   = r_in + bit_val;
            assign ge      = (x_in >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k] <= ge ? (x_in - trial) : x_in;
                    r_reg[k] <= ge ? ((r_in >> 1) + bit_val) : (r_in >> 1);
                end
            end
        end
    endgenerate

    assign root = r_reg[SQRT_STEPS-1];
    assign rem  = x_reg[SQRT_STEPS-1];

endmodule

`default_nettype wire
